// ===== rtl/qsu_pkg.sv =====
// shared types, constants and helpers for the query string unescaper
package qsu_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int CFG_BITS    = 16;
    localparam int CMP_BITS    = (LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS;

    localparam logic [CFG_BITS-1:0] MAX_LEN_RESET = CFG_BITS'(4095);

    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_APOSTROPHE = 8'h27;

    // escape phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PCT1  = 3'd1;
    localparam logic [2:0] PH_PCT2  = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_BSL1  = 3'd4;
    localparam logic [2:0] PH_BSL2  = 3'd5;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       end_of_query;
    } t_in_word;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        logic      emit;
        t_out_word word;
    } t_dec_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok     = 1'b1;
        h.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nibble = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.nibble = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.nibble = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== rtl/qsu_decoder.sv =====
// escape state, byte counter and per-word decode logic
module qsu_decoder
    import qsu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  t_in_word            i_word,
    input  logic [CFG_BITS-1:0] i_max_len,
    output t_dec_result         o_result
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [2:0]             r_phase,   n_phase;
    logic [7:0]             r_partial, n_partial;
    logic                   r_stopped, n_stopped;
    logic [LENGTH_BITS-1:0] r_count,   n_count;

    t_hex       hex;
    logic       limit_hit;
    logic       emit;
    logic       tilde_rule;
    logic [7:0] value;
    logic [7:0] dig_partial;
    logic       dig_stopped;

    assign hex       = hex_digit(i_word.query_byte);
    assign limit_hit = CMP_BITS'(r_count) >= CMP_BITS'(i_max_len);

    // one hex digit, strtol style: first bad digit freezes the value
    always_comb begin
        dig_partial = r_partial;
        dig_stopped = r_stopped;
        if (!r_stopped) begin
            if (hex.ok) begin
                dig_partial = {r_partial[3:0], hex.nibble};
            end else begin
                dig_stopped = 1'b1;
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_partial  = r_partial;
        n_stopped  = r_stopped;
        n_count    = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
        emit       = 1'b0;
        tilde_rule = 1'b0;
        value      = 8'd0;
        unique case (r_phase)
            PH_IDLE: begin
                if (!limit_hit) begin
                    if (i_word.query_byte == CH_PERCENT) begin
                        n_phase    = PH_PCT1;
                        n_partial  = 8'd0;
                        n_stopped  = 1'b0;
                        emit       = i_word.end_of_query;
                        tilde_rule = 1'b1;
                    end else if (i_word.query_byte == CH_BACKSLASH) begin
                        n_phase   = PH_SKIP;
                        n_partial = 8'd0;
                        n_stopped = 1'b0;
                        emit      = i_word.end_of_query;
                    end else begin
                        emit  = 1'b1;
                        value = (i_word.query_byte == CH_PLUS) ? CH_SPACE
                                                               : i_word.query_byte;
                    end
                end
            end
            PH_PCT1: begin
                n_partial  = dig_partial;
                n_stopped  = dig_stopped;
                n_phase    = PH_PCT2;
                emit       = i_word.end_of_query;
                tilde_rule = 1'b1;
                value      = dig_partial;
            end
            PH_PCT2: begin
                n_partial  = dig_partial;
                n_stopped  = dig_stopped;
                n_phase    = PH_IDLE;
                emit       = 1'b1;
                tilde_rule = 1'b1;
                value      = dig_partial;
            end
            PH_SKIP: begin
                n_phase = PH_BSL1;
                emit    = i_word.end_of_query;
                value   = r_partial;
            end
            PH_BSL1: begin
                n_partial = dig_partial;
                n_stopped = dig_stopped;
                n_phase   = PH_BSL2;
                emit      = i_word.end_of_query;
                value     = dig_partial;
            end
            default: begin
                n_partial = dig_partial;
                n_stopped = dig_stopped;
                n_phase   = PH_IDLE;
                emit      = 1'b1;
                value     = dig_partial;
            end
        endcase
        if (tilde_rule && value == CH_TILDE) begin
            value = CH_APOSTROPHE;
        end
        // query done: next one starts clean
        if (i_word.end_of_query) begin
            n_phase   = PH_IDLE;
            n_partial = 8'd0;
            n_stopped = 1'b0;
            n_count   = '0;
        end
    end

    assign o_result.emit              = emit;
    assign o_result.word.decoded_byte = value;
    assign o_result.word.last_byte    = i_word.end_of_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_partial <= 8'd0;
            r_stopped <= 1'b0;
            r_count   <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_stopped <= n_stopped;
            r_count   <= n_count;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_word.end_of_query |=> r_phase == PH_IDLE && r_count == '0)
        else $error("state not cleared after end of query");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && !i_word.end_of_query |=> r_count >= $past(r_count))
        else $error("byte counter went backward inside a query");

    a_escape_no_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && r_phase == PH_PCT2 |-> o_result.emit)
        else $error("second percent digit gave no byte");

endmodule

// ===== rtl/query_string_unescaper.sv =====
// top level of the query string unescaper: input register, decoder, output register
//
// input channel: i_in_valid / o_in_stall with i_in_word (query_byte, end_of_query).
// a word is taken at a rising edge where i_in_valid is high and o_in_stall is low.
// output channel: o_out_valid / i_out_stall with o_out_word (decoded_byte, last_byte).
// a word leaves at a rising edge where o_out_valid is high and i_out_stall is low.
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_data = max_query_length,
// always ready; write it only while the block is idle.
// throughput: one byte per cycle unless the receiver stalls; the input register
// feeds the decoder, which updates the escape state and fills the output register
// in the same cycle. a byte's result goes via the input and output registers to
// o_out_word. bytes swallowed by an escape or past the length limit give none.
// when the receiver stalls, the held result keeps its slot, the input register
// fills and then o_in_stall rises until the result is taken.
// synchronous reset (i_rst_n low) empties both registers, clears the escape
// state and byte count, and sets max_query_length to 4095.
module query_string_unescaper
    import qsu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_word           o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    logic                r_in_valid;
    t_in_word            r_in_word;
    logic                r_out_valid;
    t_out_word           r_out_word;
    logic [CFG_BITS-1:0] r_max_len;

    logic        out_free;
    logic        take;
    logic        in_accept;
    t_dec_result dec;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign take       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !take;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    qsu_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_word    (r_in_word),
        .i_max_len (r_max_len),
        .o_result  (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && dec.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && dec.emit) begin
            r_out_word <= dec.word;
        end
    end

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room downstream");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_in_valid == $past(i_in_valid))
        else $error("input register lost or invented a word");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && dec.emit |=> r_out_valid && r_out_word == $past(dec.word))
        else $error("decoded word not placed in output register");

endmodule
